FILE: hdl/wsvm_pkg.sv
// shared types and constants for the wavetable voice mux
// no dependencies
`timescale 1ns / 1ps
package wsvm_pkg;

	localparam int NUM_VOICES_DEF  = 8;
	localparam int SLOT_CYCLES_DEF = 15;
	localparam int RAM_BYTES_DEF   = 128;

	localparam int ADDR_W  = 7;
	localparam int VOICE_W = 3;
	localparam int MAX_VOICES = 8;

	localparam logic [ADDR_W-1:0] ACTIVE_ADDR = 7'h7F;

	// request kinds carried on tuser
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_WR   = 2'd1;
	localparam logic [1:0] REQ_ADDR = 2'd2;
	localparam logic [1:0] REQ_RD   = 2'd3;

	// byte index within a voice's register block
	localparam logic [2:0] VR_FREQ_LO  = 3'd0;
	localparam logic [2:0] VR_PHASE_LO = 3'd1;
	localparam logic [2:0] VR_FREQ_MID = 3'd2;
	localparam logic [2:0] VR_PHASE_MID = 3'd3;
	localparam logic [2:0] VR_FREQ_HI  = 3'd4;
	localparam logic [2:0] VR_PHASE_HI = 3'd5;
	localparam logic [2:0] VR_OFFSET   = 3'd6;
	localparam logic [2:0] VR_VOLUME   = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_FETCH,
		S_MUL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic cap_read;
		logic div_step;
		logic fetch;
		logic mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_run;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

FILE: hdl/wavetable_synth_voice_mux.sv
// eight-voice time-multiplexed wavetable sound block, top level
// writes, address loads and plain ticks go from input transfer straight to the output register,
// data port reads first capture the ram byte, and a tick that starts a slot of a running voice
// takes 9 steps of the bit-serial phase modulo unit, then ram fetch and multiply
// throughput: one item at a time; the next is accepted only after the output register is loaded
// reset: asynchronous, ram reads as zero until written, voice regs at defaults
// depends on wsvm_pkg, wsvm_ctrl, wsvm_dp
`timescale 1ns / 1ps
module wavetable_synth_voice_mux
	import wsvm_pkg::*;
#(
	parameter int NUM_VOICES  = NUM_VOICES_DEF,
	parameter int SLOT_CYCLES = SLOT_CYCLES_DEF,
	parameter int RAM_BYTES   = RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // wdata[7:0]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_data[7:0], dac_value[15:8], dac_channel[18:16]
	output logic [1:0]  m_tuser    // read_valid[0], slot_start[1]
);

	cmd_t    cmd;
	status_t st;
	logic [7:0] rd_data;
	logic       rd_valid;
	logic [7:0] dac_value;
	logic [2:0] dac_channel;
	logic       slot_start;

	wsvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	wsvm_dp #(
		.NUM_VOICES  (NUM_VOICES),
		.SLOT_CYCLES (SLOT_CYCLES),
		.RAM_BYTES   (RAM_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_req          (s_tuser),
		.in_byte         (s_tdata),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_read_data   (rd_data),
		.out_read_valid  (rd_valid),
		.out_dac_value   (dac_value),
		.out_dac_channel (dac_channel),
		.out_slot_start  (slot_start)
	);

	assign m_tdata = {5'd0, dac_channel, dac_value, rd_data};
	assign m_tuser = {slot_start, rd_valid};

endmodule

FILE: hdl/wsvm_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
module wsvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/wsvm_ctrl.sv
// sequencing state machine for the wavetable voice mux
// depends on wsvm_pkg
`timescale 1ns / 1ps
module wsvm_ctrl
	import wsvm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (st.is_read) state_d = S_READ;
					else if (st.is_run) state_d = S_DIV;
					else state_d = S_DONE;
				end
			end
			S_READ:  state_d = S_DONE;
			S_DIV: begin
				if (st.div_last) state_d = S_FETCH;
			end
			S_FETCH: state_d = S_MUL;
			S_MUL:   state_d = S_DONE;
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			S_READ:  cmd.cap_read = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_FETCH: cmd.fetch = 1'b1;
			S_MUL:   cmd.mul = 1'b1;
			S_DONE:  cmd.out_load = st.out_free;
			default: cmd = '0;
		endcase
	end

	a_div_to_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && st.div_last) |=> state_q == S_FETCH)
		else $error("divider did not hand over to fetch");
	a_fetch_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> state_q == S_MUL)
		else $error("fetch not followed by multiply");
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && st.is_read) |=> (state_q == S_READ && cmd.cap_read))
		else $error("read transfer did not capture ram data");

endmodule

FILE: hdl/wsvm_dp.sv
// datapath: port registers, voice registers, wave ram, modulo unit, dac
// depends on wsvm_pkg and wsvm_ram
`timescale 1ns / 1ps
module wsvm_dp
	import wsvm_pkg::*;
#(
	parameter int NUM_VOICES  = NUM_VOICES_DEF,
	parameter int SLOT_CYCLES = SLOT_CYCLES_DEF,
	parameter int RAM_BYTES   = RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     st,
	input  logic [1:0]  in_req,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_read_data,
	output logic        out_read_valid,
	output logic [7:0]  out_dac_value,
	output logic [2:0]  out_dac_channel,
	output logic        out_slot_start
);

	logic [ADDR_W-1:0]  port_addr_q;
	logic               auto_inc_q;
	logic [17:0]        freq_q  [MAX_VOICES];
	logic [23:0]        phase_q [MAX_VOICES];
	logic [8:0]         len_q   [MAX_VOICES];
	logic [7:0]         off_q   [MAX_VOICES];
	logic [3:0]         vol_q   [MAX_VOICES];
	logic [2:0]         active_q;
	logic [3:0]         slot_q;
	logic [VOICE_W-1:0] cur_q;
	logic [7:0]         dac_q;
	logic [VOICE_W-1:0] dvoice_q;
	logic [RAM_BYTES-1:0] ram_vld_q;
	logic               rvld_s1;
	logic [VOICE_W-1:0] vidx_q;
	logic [8:0]         hi_q;
	logic [15:0]        lo_q;
	logic [8:0]         rem_q;
	logic [3:0]         cnt_q;
	logic               odd_q;
	logic [7:0]         rd_q;
	logic               rv_q;
	logic               start_q;

	logic [ADDR_W-1:0]  raddr;
	logic [7:0]         rdata;
	logic [7:0]         rbyte;
	logic               we;
	logic [2:0]         wv;
	logic [2:0]         wk;
	logic               slot0;
	logic [24:0]        sum;
	logic [9:0]         r10;
	logic [8:0]         r_next;
	logic [7:0]         samp_addr;
	logic [3:0]         nib;
	logic [3:0]         slot_inc;
	logic [VOICE_W-1:0] next_voice;

	assign we    = cmd.accept && in_req == REQ_WR;
	assign wv    = port_addr_q[5:3];
	assign wk    = port_addr_q[2:0];
	assign slot0 = slot_q == 4'd0;
	assign sum   = 25'(phase_q[cur_q]) + 25'(freq_q[cur_q]);

	assign st.is_read  = in_req == REQ_RD;
	assign st.is_run   = in_req == REQ_TICK && slot0 && freq_q[cur_q] != 18'd0;
	assign st.div_last = cnt_q == 4'd8;
	assign st.out_free = !out_valid || out_ready;

	// one restoring step of (phase + freq) >> 16 modulo length
	assign r10    = {rem_q, hi_q[8]};
	assign r_next = (r10 >= {1'b0, len_q[vidx_q]}) ? 9'(r10 - {1'b0, len_q[vidx_q]})
		: r10[8:0];

	assign samp_addr = rem_q[7:0] + off_q[vidx_q];
	assign raddr     = cmd.fetch ? samp_addr[7:1] : port_addr_q;
	assign rbyte     = rvld_s1 ? rdata : 8'd0;
	assign nib       = odd_q ? rbyte[7:4] : rbyte[3:0];
	assign slot_inc  = slot_q + 4'd1;

	always_comb begin
		if (cur_q == '0 || 4'(cur_q) + 4'(active_q) < 4'(NUM_VOICES)) begin
			next_voice = VOICE_W'(NUM_VOICES - 1);
		end else begin
			next_voice = cur_q - 1'b1;
		end
	end

	wsvm_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (port_addr_q),
		.wdata (in_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_addr_q <= '0;
			auto_inc_q  <= 1'b0;
			active_q    <= '0;
			slot_q      <= '0;
			cur_q       <= VOICE_W'(NUM_VOICES - 1);
			dac_q       <= '0;
			dvoice_q    <= VOICE_W'(NUM_VOICES - 1);
			ram_vld_q   <= '0;
			rvld_s1     <= 1'b0;
			out_valid   <= 1'b0;
			for (int i = 0; i < MAX_VOICES; i++) begin
				freq_q[i]  <= '0;
				phase_q[i] <= '0;
				len_q[i]   <= 9'd256;
				off_q[i]   <= '0;
				vol_q[i]   <= '0;
			end
		end else begin
			rvld_s1 <= ram_vld_q[raddr];
			if (cmd.accept) begin
				case (in_req)
					REQ_TICK: begin
						if (slot0) begin
							dvoice_q <= cur_q;
							if (freq_q[cur_q] == 18'd0) dac_q <= '0;
						end
						if (slot_inc >= 4'(SLOT_CYCLES)) begin
							slot_q <= '0;
							cur_q  <= next_voice;
						end else begin
							slot_q <= slot_inc;
						end
					end
					REQ_WR: begin
						ram_vld_q[port_addr_q] <= 1'b1;
						if (port_addr_q[6] && 4'(wv) < 4'(NUM_VOICES)) begin
							case (wk)
								VR_FREQ_LO:   freq_q[wv][7:0]    <= in_byte;
								VR_PHASE_LO:  phase_q[wv][7:0]   <= in_byte;
								VR_FREQ_MID:  freq_q[wv][15:8]   <= in_byte;
								VR_PHASE_MID: phase_q[wv][15:8]  <= in_byte;
								VR_FREQ_HI: begin
									freq_q[wv][17:16] <= in_byte[1:0];
									len_q[wv] <= 9'd256 - {1'b0, in_byte[7:2], 2'b00};
								end
								VR_PHASE_HI:  phase_q[wv][23:16] <= in_byte;
								VR_OFFSET:    off_q[wv]          <= in_byte;
								VR_VOLUME:    vol_q[wv]          <= in_byte[3:0];
								default:      vol_q[wv]          <= in_byte[3:0];
							endcase
						end
						if (port_addr_q == ACTIVE_ADDR) active_q <= in_byte[6:4];
						if (auto_inc_q) port_addr_q <= port_addr_q + 1'b1;
					end
					REQ_ADDR: begin
						port_addr_q <= in_byte[6:0];
						auto_inc_q  <= in_byte[7];
					end
					REQ_RD: begin
						if (auto_inc_q) port_addr_q <= port_addr_q + 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.fetch) begin
				phase_q[vidx_q] <= {rem_q[7:0], lo_q};
			end
			if (cmd.mul) begin
				dac_q <= 8'(nib) * 8'(vol_q[vidx_q]);
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// working registers of one item, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vidx_q  <= cur_q;
			hi_q    <= sum[24:16];
			lo_q    <= sum[15:0];
			rem_q   <= '0;
			cnt_q   <= '0;
			rd_q    <= '0;
			rv_q    <= in_req == REQ_RD;
			start_q <= in_req == REQ_TICK && slot0;
		end
		if (cmd.div_step) begin
			rem_q <= r_next;
			hi_q  <= {hi_q[7:0], 1'b0};
			cnt_q <= cnt_q + 4'd1;
		end
		if (cmd.fetch) begin
			odd_q <= rem_q[0];
		end
		if (cmd.cap_read) begin
			rd_q <= rbyte;
		end
		if (cmd.out_load) begin
			out_read_data   <= rd_q;
			out_read_valid  <= rv_q;
			out_dac_value   <= dac_q;
			out_dac_channel <= dvoice_q;
			out_slot_start  <= start_q;
		end
	end

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> rem_q < len_q[vidx_q])
		else $error("phase remainder not below wave length");
	a_dac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_dac_value <= 8'd225)
		else $error("dac level out of range");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < 4'(SLOT_CYCLES))
		else $error("slot counter past slot length");

endmodule

FILE: sim/wavetable_synth_voice_mux_test.sv
// self-checking testbench for wavetable_synth_voice_mux: bus and tick transfers,
// each result checked against a cycle-free voice mux model kept in this file
// depends on wsvm_pkg and the wavetable_synth_voice_mux rtl
`timescale 1ns / 1ps
module wavetable_synth_voice_mux_test;
	import wsvm_pkg::*;

	localparam int VOICES   = 8;
	localparam int SLOT_LEN = 15;
	localparam int N_RANDOM = 1020;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic       rd_valid;
		logic [7:0] dac;
		logic [2:0] chan;
		logic       start;
	} voice_out_t;

	typedef struct {
		logic [1:0] req;
		logic [7:0] data;
		bit         typed;
		voice_out_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	wavetable_synth_voice_mux i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// model state
	logic [7:0]  ram_m [128];
	logic [6:0]  addr_m;
	logic        inc_m;
	logic [17:0] freq_m [VOICES];
	logic [23:0] phase_m [VOICES];
	logic [8:0]  len_m [VOICES];
	logic [7:0]  ofs_m [VOICES];
	logic [3:0]  vol_m [VOICES];
	logic [2:0]  active_m;
	logic [3:0]  slot_m;
	logic [2:0]  voice_m;
	logic [7:0]  dac_m;
	logic [2:0]  dac_voice_m;

	voice_out_t pending_results[$];
	int  errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_starts = 0;
	int  n_reads = 0;
	int  tx_idle = 0;
	int  rx_idle = 0;
	bit  long_hold_req = 0;
	int  hold_left = 0;
	longint cycles = 0;

	function automatic void model_reset();
		for (int i = 0; i < 128; i++) ram_m[i] = '0;
		for (int v = 0; v < VOICES; v++) begin
			freq_m[v] = '0; phase_m[v] = '0; len_m[v] = 9'd256; ofs_m[v] = '0; vol_m[v] = '0;
		end
		addr_m = '0; inc_m = 0; active_m = '0; slot_m = '0;
		voice_m = 3'(VOICES - 1); dac_m = '0; dac_voice_m = 3'(VOICES - 1);
	endfunction

	function automatic void run_voice(int v);
		logic [31:0] sum;
		logic [7:0]  ptr, sa, smp;
		if (freq_m[v] == 0) begin
			dac_m = '0;
			return;
		end
		sum = (32'(phase_m[v]) + 32'(freq_m[v])) % (32'(len_m[v]) << 16);
		phase_m[v] = sum[23:0];
		ptr = phase_m[v][23:16];
		sa = ptr + ofs_m[v];
		smp = ram_m[sa[7:1]];
		if (ptr[0]) smp = smp >> 4;
		dac_m = 8'(smp[3:0]) * 8'(vol_m[v]);
	endfunction

	function automatic voice_out_t voice_mux_step(logic [1:0] req, logic [7:0] data);
		voice_out_t r;
		int v;
		r = '0;
		case (req)
			REQ_TICK: begin
				if (slot_m == 0) begin
					r.start = 1;
					dac_voice_m = voice_m;
					run_voice(voice_m);
				end
				slot_m++;
				if (slot_m >= SLOT_LEN) begin
					slot_m = 0;
					if (voice_m == 0 || int'(voice_m) + int'(active_m) < VOICES)
						voice_m = 3'(VOICES - 1);
					else
						voice_m--;
				end
			end
			REQ_WR: begin
				ram_m[addr_m] = data;
				if (addr_m[6]) begin
					v = addr_m[5:3];
					case (addr_m[2:0])
						VR_FREQ_LO:   freq_m[v][7:0] = data;
						VR_PHASE_LO:  phase_m[v][7:0] = data;
						VR_FREQ_MID:  freq_m[v][15:8] = data;
						VR_PHASE_MID: phase_m[v][15:8] = data;
						VR_FREQ_HI: begin
							freq_m[v][17:16] = data[1:0];
							len_m[v] = 9'd256 - {1'b0, data & 8'hFC};
						end
						VR_PHASE_HI:  phase_m[v][23:16] = data;
						VR_OFFSET:    ofs_m[v] = data;
						VR_VOLUME:    vol_m[v] = data[3:0];
						default: ;
					endcase
					if (addr_m == ACTIVE_ADDR) active_m = data[6:4];
				end
				if (inc_m) addr_m++;
			end
			REQ_ADDR: begin
				addr_m = data[6:0];
				inc_m = data[7];
			end
			REQ_RD: begin
				r.rd_byte = ram_m[addr_m];
				r.rd_valid = 1;
				if (inc_m) addr_m++;
			end
			default: ;
		endcase
		r.dac = dac_m;
		r.chan = dac_voice_m;
		return r;
	endfunction

	// directed part: expectations typed in only where obvious
	stim_row_t rows[] = '{
		'{REQ_TICK, 8'h00, 1, '{8'h00, 1'b0, 8'd0, 3'd7, 1'b1}},  // first tick after reset
		'{REQ_RD,   8'h00, 1, '{8'h00, 1'b1, 8'd0, 3'd7, 1'b0}},  // ram clear after reset
		'{REQ_ADDR, 8'h80, 0, '0},
		'{REQ_WR,   8'hFF, 0, '0},
		'{REQ_WR,   8'h00, 0, '0},
		'{REQ_ADDR, 8'h00, 0, '0},
		'{REQ_RD,   8'h00, 1, '{8'hFF, 1'b1, 8'd0, 3'd7, 1'b0}},
		'{REQ_ADDR, 8'hF8, 0, '0},                                 // voice 7 regs, auto-increment
		'{REQ_WR,   8'hFF, 0, '0},
		'{REQ_WR,   8'h00, 0, '0},
		'{REQ_WR,   8'hFF, 0, '0},
		'{REQ_WR,   8'h00, 0, '0},
		'{REQ_WR,   8'hFF, 0, '0},                                 // shortest wave length
		'{REQ_WR,   8'h00, 0, '0},
		'{REQ_WR,   8'hFF, 0, '0},                                 // largest offset
		'{REQ_WR,   8'h7F, 0, '0},                                 // full volume, all voices in use
		'{REQ_ADDR, 8'h7F, 0, '0},
		'{REQ_RD,   8'h00, 1, '{8'h7F, 1'b1, 8'd0, 3'd7, 1'b0}},
		'{REQ_ADDR, 8'hFF, 0, '0},                                 // address wraps to zero
		'{REQ_WR,   8'h5A, 0, '0},
		'{REQ_RD,   8'h00, 1, '{8'hFF, 1'b1, 8'd0, 3'd7, 1'b0}},
		'{REQ_ADDR, 8'hC8, 0, '0},                                 // voice 1 zero frequency
		'{REQ_WR,   8'h00, 0, '0}
	};

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver, with a long hold-off counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			hold_left <= 0;
		end else if (long_hold_req && hold_left == 0) begin
			m_tready <= 0;
			hold_left <= 400;
		end else if (hold_left > 1) begin
			m_tready <= 0;
			hold_left <= hold_left - 1;
		end else begin
			if (hold_left == 1) hold_left <= -1;  // hold used up
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		voice_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tuser[0], m_tdata[15:8], m_tdata[18:16], m_tuser[1]};
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, got);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got !== want || m_tdata[23:19] !== '0) begin
					errors++;
					$display("%0t mismatch: expected rd=%h rv=%b dac=%0d ch=%0d st=%b",
						$time, want.rd_byte, want.rd_valid, want.dac, want.chan, want.start);
					$display("%0t            actual rd=%h rv=%b dac=%0d ch=%0d st=%b pad=%h",
						$time, got.rd_byte, got.rd_valid, got.dac, got.chan, got.start,
						m_tdata[23:19]);
				end
			end
		end
	end

	// valid stays up after a transfer until the next send or drain replaces it
	task automatic send(logic [1:0] req, logic [7:0] data, bit typed, voice_out_t typed_want);
		voice_out_t w;
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= req;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		w = voice_mux_step(req, data);
		if (typed && w !== typed_want) begin
			errors++;
			$display("%0t table row disagrees with model: expected %h model %h",
				$time, typed_want, w);
		end
		pending_results.push_back(typed ? typed_want : w);
		n_sent++;
		if (w.start) n_starts++;
		if (w.rd_valid) n_reads++;
	endtask

	task automatic send_random();
		int pick;
		logic [1:0] req;
		logic [7:0] data;
		pick = $urandom_range(99);
		data = 8'($urandom);
		if (pick < 55) req = REQ_TICK;
		else if (pick < 75) req = REQ_WR;
		else if (pick < 87) begin
			req = REQ_ADDR;
			case ($urandom_range(3))
				0, 1: data = {1'b1, 1'b1, data[5:0]};  // voice registers
				2:    data = {1'b1, 1'b0, data[5:0]};  // wave area
				default: ;
			endcase
		end else req = REQ_RD;
		send(req, data, 0, '0);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		model_reset();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = REQ_TICK;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) send(rows[i].req, rows[i].data, rows[i].typed, rows[i].want);
		repeat (40) send(REQ_TICK, 8'h00, 0, '0);
		// fill the wave area with random bytes
		send(REQ_ADDR, 8'h80, 0, '0);
		repeat (64) send(REQ_WR, 8'($urandom), 0, '0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
			rx_idle = (ph == 0) ? 78 : (ph == 1) ? 17 : 0;
			for (int k = 0; k < N_RANDOM / 3; k++) begin
				if (ph == 2 && k == 20) long_hold_req = 1;
				if (ph == 2 && k == 60) long_hold_req = 0;
				send_random();
			end
			// sender waits for every outstanding result
			drain();
		end

		repeat (30) @(posedge clk);
		$display("covered %0d transfers: %0d reads, %0d voice slots, %0d results checked",
			n_sent, n_reads, n_starts, n_checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
